>>> rtl/ffb_pkg.sv
// shared types and constants of the friction factor blend unit
package ffb_pkg;

  localparam logic [31:0] RE_MIN        = 32'd256;
  localparam logic [31:0] RE_LAM_END    = 32'd102400;
  localparam logic [31:0] RE_TURB_START = 32'd1280000;
  localparam logic [31:0] PSI_SPAN      = 32'd1177600;
  localparam logic [31:0] LAM_K         = 32'd110;
  localparam logic [49:0] TURB_K        = 50'd416582965531771;
  localparam logic [41:0] PSI_RECIP     = 42'd3916173589018;

  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 32;
  localparam int FT_STEPS = 24;

  typedef enum logic [1:0] {
    REG_LAMINAR   = 2'd0,
    REG_BLEND     = 2'd1,
    REG_TURBULENT = 2'd2
  } region_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] d;
    logic [31:0] quo;
  } dv_t;

  typedef struct packed {
    logic        valid;
    region_t     region;
    logic [31:0] fl;
    logic        p_zero;
    logic [31:0] sp;
    logic [32:0] sm;
  } side_t;

endpackage

>>> rtl/ffb_in_if.sv
// input channel carrying one reynolds number per beat
interface ffb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] reynolds;
  modport source (output valid, output reynolds, input ready);
  modport sink (input valid, input reynolds, output ready);
endinterface

>>> rtl/ffb_out_if.sv
// output channel carrying one friction factor and region per beat
interface ffb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] friction;
  logic [1:0]  region;
  modport source (output valid, output friction, output region, input ready);
  modport sink (input valid, input friction, input region, output ready);
endinterface

>>> rtl/friction_factor_blend_unit.sv
// top level of the friction factor blend unit
//
// req carries one reynolds number (unsigned q24.8) per beat; rsp returns one
// friction factor (unsigned q8.24) and a region code per beat, in order.
// region: laminar below 400, blended from 400 to 5000, turbulent above.
// the datapath is a row of cells, one digit per cell per enabled cycle:
//   input register, 32 cells for sqrt(re) with the laminar divider and a
//   two-stage psi reciprocal multiply alongside, 32 cells for the fourth
//   root and the two blend weights, 24 cells for the turbulent divider,
//   then a multiply stage and the output register.
// throughput is one beat per cycle while rsp keeps up.
// reset clears every valid bit, so nothing comes out until fed.
// when rsp stalls with a result waiting, the whole row holds and req.ready
// falls; no beat is dropped or duplicated.
module friction_factor_blend_unit import ffb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ffb_in_if.sink    req,
  ffb_out_if.source rsp
);

  logic        en;
  logic        v0;
  logic [31:0] r0;
  region_t     reg0;
  logic [31:0] rc;
  region_t     rc_region;

  sq_t   g1_sq  [0:SQ_STEPS];
  dv_t   g1_lam [0:DV_STEPS];
  side_t g1_sd  [0:SQ_STEPS];
  sq_t   g2_q   [0:SQ_STEPS];
  sq_t   g2_sp  [0:SQ_STEPS];
  sq_t   g2_sm  [0:SQ_STEPS];
  side_t g2_sd  [0:SQ_STEPS];
  dv_t   g3_dv  [0:FT_STEPS];
  side_t g3_sd  [0:FT_STEPS];

  logic [20:0] px;
  logic [41:0] psi_h;
  logic [41:0] psi_l;
  logic [63:0] psi_prod;
  logic [31:0] psi_d [2:SQ_STEPS];

  logic [31:0] fl;
  logic [31:0] p;
  logic [31:0] q;
  logic [49:0] dvd;

  assign en        = ~rsp.valid | rsp.ready;
  assign req.ready = en;

  always_comb begin
    rc = (req.reynolds < RE_MIN) ? RE_MIN : req.reynolds;
    if (rc < RE_LAM_END) begin
      rc_region = REG_LAMINAR;
    end else if (rc < RE_TURB_START) begin
      rc_region = REG_BLEND;
    end else begin
      rc_region = REG_TURBULENT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= req.valid;
    end
    if (en) begin
      r0   <= rc;
      reg0 <= rc_region;
    end
  end

  // first row: sqrt(re), laminar divider, psi by reciprocal multiply
  assign g1_sq[0]  = '{rad: {r0, 32'd0}, rem: '0, root: '0};
  assign g1_lam[0] = '{rem: LAM_K, lo: '0, d: r0, quo: '0};
  assign g1_sd[0]  = '{valid: v0, region: reg0, fl: '0, p_zero: 1'b0, sp: '0, sm: '0};

  assign px       = (reg0 == REG_BLEND) ? 21'(r0 - RE_LAM_END) : 21'd0;
  assign psi_prod = {1'b0, psi_h, 21'd0} + {22'd0, psi_l};

  always_ff @(posedge clk) begin
    if (en) begin
      psi_h    <= 42'(px) * 42'(PSI_RECIP[41:21]);
      psi_l    <= 42'(px) * 42'(PSI_RECIP[20:0]);
      psi_d[2] <= psi_prod[61:30];
    end
  end

  for (genvar k = 2; k < SQ_STEPS; k++) begin : g_psi
    always_ff @(posedge clk) begin
      if (en) begin
        psi_d[k+1] <= psi_d[k];
      end
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_row1
    ffb_sqrt_cell u_sq (.clk(clk), .en(en), .a(g1_sq[k]), .y(g1_sq[k+1]));
    ffb_div_cell u_lam (.clk(clk), .en(en), .a(g1_lam[k]), .y(g1_lam[k+1]));
    always_ff @(posedge clk) begin
      if (rst) begin
        g1_sd[k+1].valid <= 1'b0;
      end else if (en) begin
        g1_sd[k+1] <= g1_sd[k];
      end
    end
  end

  // second row: fourth root and the two blend weights
  assign fl = g1_lam[DV_STEPS].quo +
              32'({g1_lam[DV_STEPS].rem, 1'b0} >= {1'b0, g1_lam[DV_STEPS].d});
  assign p  = psi_d[SQ_STEPS];

  assign g2_q[0]  = '{rad: {g1_sq[SQ_STEPS].root, 32'd0}, rem: '0, root: '0};
  assign g2_sp[0] = '{rad: {p, 32'd0}, rem: '0, root: '0};
  assign g2_sm[0] = '{rad: {(~p) + 32'd1, 32'd0}, rem: '0, root: '0};
  assign g2_sd[0] = '{valid: g1_sd[SQ_STEPS].valid, region: g1_sd[SQ_STEPS].region,
                      fl: fl, p_zero: (p == 32'd0), sp: '0, sm: '0};

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_row2
    ffb_sqrt_cell u_q (.clk(clk), .en(en), .a(g2_q[k]), .y(g2_q[k+1]));
    ffb_sqrt_cell u_sp (.clk(clk), .en(en), .a(g2_sp[k]), .y(g2_sp[k+1]));
    ffb_sqrt_cell u_sm (.clk(clk), .en(en), .a(g2_sm[k]), .y(g2_sm[k+1]));
    always_ff @(posedge clk) begin
      if (rst) begin
        g2_sd[k+1].valid <= 1'b0;
      end else if (en) begin
        g2_sd[k+1] <= g2_sd[k];
      end
    end
  end

  // third row: turbulent divider, rounding folded into the dividend
  assign q   = g2_q[SQ_STEPS].root;
  assign dvd = TURB_K + 50'(q[31:1]);

  assign g3_dv[0] = '{rem: {6'd0, dvd[49:24]}, lo: {dvd[23:0], 8'd0}, d: q, quo: '0};
  assign g3_sd[0] = '{valid: g2_sd[SQ_STEPS].valid, region: g2_sd[SQ_STEPS].region,
                      fl: g2_sd[SQ_STEPS].fl, p_zero: g2_sd[SQ_STEPS].p_zero,
                      sp: g2_sp[SQ_STEPS].root,
                      sm: g2_sd[SQ_STEPS].p_zero ? 33'h1_0000_0000
                                                 : {1'b0, g2_sm[SQ_STEPS].root}};

  for (genvar k = 0; k < FT_STEPS; k++) begin : g_row3
    ffb_div_cell u_ft (.clk(clk), .en(en), .a(g3_dv[k]), .y(g3_dv[k+1]));
    always_ff @(posedge clk) begin
      if (rst) begin
        g3_sd[k+1].valid <= 1'b0;
      end else if (en) begin
        g3_sd[k+1] <= g3_sd[k];
      end
    end
  end

  ffb_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .sd       (g3_sd[FT_STEPS]),
    .ft       (g3_dv[FT_STEPS].quo),
    .valid    (rsp.valid),
    .friction (rsp.friction),
    .region   (rsp.region)
  );

endmodule

>>> rtl/ffb_sqrt_cell.sv
// one digit step of a pipelined integer square root
module ffb_sqrt_cell import ffb_pkg::*; (
  input  logic clk,
  input  logic en,
  input  sq_t  a,
  output sq_t  y
);

  logic [35:0] t;
  logic [35:0] trial;
  logic [35:0] diff;
  sq_t         nxt;

  always_comb begin
    t       = {a.rem, a.rad[63:62]};
    trial   = {2'b00, a.root, 2'b01};
    diff    = t - trial;
    nxt.rad = {a.rad[61:0], 2'b00};
    if (t >= trial) begin
      nxt.rem  = diff[33:0];
      nxt.root = {a.root[30:0], 1'b1};
    end else begin
      nxt.rem  = t[33:0];
      nxt.root = {a.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= nxt;
    end
  end

endmodule

>>> rtl/ffb_div_cell.sv
// one quotient bit step of a pipelined restoring divider
module ffb_div_cell import ffb_pkg::*; (
  input  logic clk,
  input  logic en,
  input  dv_t  a,
  output dv_t  y
);

  logic [32:0] t;
  logic [32:0] dd;
  logic [32:0] diff;
  dv_t         nxt;

  always_comb begin
    t      = {a.rem, a.lo[31]};
    dd     = {1'b0, a.d};
    diff   = t - dd;
    nxt.lo = {a.lo[30:0], 1'b0};
    nxt.d  = a.d;
    if (t >= dd) begin
      nxt.rem = diff[31:0];
      nxt.quo = {a.quo[30:0], 1'b1};
    end else begin
      nxt.rem = t[31:0];
      nxt.quo = {a.quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= nxt;
    end
  end

endmodule

>>> rtl/ffb_blend.sv
// weighting multipliers, rounding, region select and output register
module ffb_blend import ffb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  side_t       sd,
  input  logic [31:0] ft,
  output logic        valid,
  output logic [31:0] friction,
  output logic [1:0]  region
);

  logic        vm;
  region_t     regm;
  logic [31:0] flm;
  logic [31:0] ftm;
  logic [63:0] pa;
  logic [64:0] pb;
  logic [32:0] ra;
  logic [33:0] rb;
  logic [34:0] sum;
  logic [31:0] f_next;
  logic [64:0] pa_r;
  logic [65:0] pb_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= sd.valid;
    end
    if (en) begin
      regm <= sd.region;
      flm  <= sd.fl;
      ftm  <= ft;
      pa   <= 64'(sd.sp) * 64'(ft);
      pb   <= 65'(sd.sm) * 65'(sd.fl);
    end
  end

  always_comb begin
    pa_r = {1'b0, pa} + 65'h0_8000_0000;
    pb_r = {1'b0, pb} + 66'h0_8000_0000;
    ra   = pa_r[64:32];
    rb   = pb_r[65:32];
    sum  = {2'b00, ra} + {1'b0, rb};
    unique case (regm)
      REG_LAMINAR:   f_next = flm;
      REG_TURBULENT: f_next = ftm;
      default:       f_next = (sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : sum[31:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= vm;
    end
    if (en) begin
      friction <= f_next;
      region   <= regm;
    end
  end

endmodule

>>> sim/friction_factor_blend_unit_tb.sv
// testbench of the friction factor blend unit: reynolds numbers checked against a predictor
`timescale 1ns / 1ps

module friction_factor_blend_unit_tb;
  import ffb_pkg::*;

  typedef struct packed {
    logic [31:0] friction;
    region_t     region;
  } factor_t;

  logic clk;
  logic rst;
  bit   idling = 1'b1;
  int   errors = 0;
  int   beats_sent = 0;
  int   beats_checked = 0;
  int   region_seen [3] = '{0, 0, 0};
  factor_t expected_factors [$];

  ffb_in_if  req ();
  ffb_out_if rsp ();

  friction_factor_blend_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("friction_factor_blend_unit_tb: errors");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] clip32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  function automatic logic [63:0] laminar(logic [63:0] r);
    logic [63:0] num;
    num = 64'(LAM_K) << 32;
    return num / r + (((num % r) * 2 >= r) ? 64'd1 : 64'd0);
  endfunction

  function automatic logic [63:0] turbulent(logic [63:0] r);
    logic [63:0] s;
    logic [63:0] q;
    s = int_sqrt(r << 32);
    q = int_sqrt(s << 32);
    if (q == 0) q = 1;
    return (64'(TURB_K) + q / 2) / q;
  endfunction

  function automatic logic [63:0] weigh(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 31)) >> 32;
  endfunction

  function automatic factor_t friction_of(logic [31:0] reynolds);
    factor_t     o;
    logic [63:0] r;
    logic [63:0] f;
    logic [63:0] fl;
    logic [63:0] ft;
    logic [63:0] p;
    logic [63:0] m;
    logic [63:0] sp;
    logic [63:0] sm;
    r = 64'(reynolds);
    if (r < 64'(RE_MIN)) r = 64'(RE_MIN);
    if (r < 64'(RE_LAM_END)) begin
      f = laminar(r);
      o.region = REG_LAMINAR;
    end else if (r < 64'(RE_TURB_START)) begin
      fl = clip32(laminar(r));
      ft = clip32(turbulent(r));
      p = ((r - 64'(RE_LAM_END)) << 32) / 64'(PSI_SPAN);
      if (p > (64'd1 << 32)) p = 64'd1 << 32;
      m = (64'd1 << 32) - p;
      sp = (p >= (64'd1 << 32)) ? (64'd1 << 32) : int_sqrt(p << 32);
      sm = (m >= (64'd1 << 32)) ? (64'd1 << 32) : int_sqrt(m << 32);
      f = weigh(sp, ft) + weigh(sm, fl);
      o.region = REG_BLEND;
    end else begin
      f = turbulent(r);
      o.region = REG_TURBULENT;
    end
    f = clip32(f);
    o.friction = f[31:0];
    return o;
  endfunction

  task automatic send_reynolds(logic [31:0] value);
    while (idling && $urandom_range(99) < 24) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.reynolds <= value;
    do @(posedge clk); while (!req.ready);
    expected_factors.push_back(friction_of(value));
    beats_sent++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_factors.size() == 0) begin
          $display("%0t: unexpected beat friction %h region %0d", $time,
                   rsp.friction, rsp.region);
          errors++;
        end else begin
          factor_t e;
          e = expected_factors.pop_front();
          if (rsp.friction !== e.friction) begin
            $display("%0t: friction expected %h actual %h", $time, e.friction,
                     rsp.friction);
            errors++;
          end
          if (rsp.region !== e.region) begin
            $display("%0t: region expected %0d actual %0d", $time, e.region,
                     rsp.region);
            errors++;
          end
          region_seen[e.region]++;
          beats_checked++;
        end
      end
      rsp.ready <= !idling || ($urandom_range(99) >= 24);
    end
  end

  task automatic test_extremes();
    logic [31:0] values [$];
    values = {32'd0, 32'd1, 32'd255, 32'd256, 32'd257, 32'd12345,
              32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h0001_0000};
    foreach (values[i]) send_reynolds(values[i]);
  endtask

  task automatic test_region_bounds();
    logic [31:0] values [$];
    values = {RE_LAM_END - 1, RE_LAM_END, RE_LAM_END + 1, 32'd500000,
              32'd691200, RE_TURB_START - 1, RE_TURB_START, RE_TURB_START + 1};
    foreach (values[i]) send_reynolds(values[i]);
  endtask

  task automatic test_random_mix(int count);
    logic [31:0] v;
    repeat (count) begin
      case ($urandom_range(3))
        0: v = $urandom_range(RE_LAM_END - 1);
        1: v = $urandom_range(RE_TURB_START - 1, RE_LAM_END);
        2: v = $urandom_range(32'd40_000_000, RE_TURB_START);
        default: v = $urandom;
      endcase
      send_reynolds(v);
    end
  endtask

  task automatic test_back_to_back(int count);
    idling = 1'b0;
    test_random_mix(count);
    idling = 1'b1;
  endtask

  initial begin
    rst          <= 1'b1;
    req.valid    <= 1'b0;
    req.reynolds <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_region_bounds();
    test_random_mix(700);
    test_back_to_back(300);
    test_random_mix(350);
    req.valid <= 1'b0;
    while (expected_factors.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("covered %0d beats, %0d checked: %0d laminar, %0d blended, %0d turbulent",
             beats_sent, beats_checked, region_seen[0], region_seen[1], region_seen[2]);
    if (errors == 0 && expected_factors.size() == 0) begin
      $display("friction_factor_blend_unit_tb: clean");
    end else begin
      $display("friction_factor_blend_unit_tb: errors");
    end
    $finish;
  end

endmodule

>>> friction_factor_blend_unit.f
rtl/ffb_pkg.sv
rtl/ffb_in_if.sv
rtl/ffb_out_if.sv
rtl/ffb_sqrt_cell.sv
rtl/ffb_div_cell.sv
rtl/ffb_blend.sv
rtl/friction_factor_blend_unit.sv
sim/friction_factor_blend_unit_tb.sv
